/* hdl/idbt_pkg.sv */
// ----------------------------------------------------------------------------
// idbt_pkg
// Shared types and constants for the inverse-depth buffer test core.
// ----------------------------------------------------------------------------
package idbt_pkg;

    localparam int DEPTH_W    = 32;   // depth and reciprocal width, Q16.16
    localparam int POS_X_W    = 10;
    localparam int POS_Y_W    = 9;
    localparam int POS_CMP_W  = 13;   // holds screen sizes up to 4096
    localparam int ADDR_MAX_W = 24;   // 4096 x 4096 entries at most
    localparam int S_DATA_W   = 56;
    localparam int M_DATA_W   = 32;

    // request handed from the front end to the back end
    typedef struct packed {
        logic                  clear;
        logic                  onscreen;
        logic [ADDR_MAX_W-1:0] addr;
        logic [DEPTH_W-1:0]    depth;
    } item_t;

endpackage

/* hdl/idbt_ram.sv */
// ----------------------------------------------------------------------------
// idbt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module idbt_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/idbt_front.sv */
// ----------------------------------------------------------------------------
// idbt_front
// Accepts requests, works out pixel address and on-screen flag, and holds
// them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module idbt_front #(
    parameter int SCREEN_COLS = 640,
    parameter int SCREEN_ROWS = 480
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [idbt_pkg::S_DATA_W-1:0]  s_axis_tdata,
    input  logic [0:0]                     s_axis_tuser,
    input  logic                           hold,
    output logic                           q_valid,
    output idbt_pkg::item_t                q_item,
    input  logic                           q_pop
);

    localparam int AW = idbt_pkg::ADDR_MAX_W;
    localparam int CW = idbt_pkg::POS_CMP_W;

    idbt_pkg::item_t                q_mem_reg [2];
    logic                           wr_ptr_reg, wr_ptr_next;
    logic                           rd_ptr_reg, rd_ptr_next;
    logic [1:0]                     cnt_reg, cnt_next;

    logic [idbt_pkg::POS_X_W-1:0]   pos_x;
    logic [idbt_pkg::POS_Y_W-1:0]   pos_y;
    logic [idbt_pkg::DEPTH_W-1:0]   depth;
    idbt_pkg::item_t                item;
    logic                           push;

    assign pos_x = s_axis_tdata[9:0];
    assign pos_y = s_axis_tdata[18:10];
    assign depth = s_axis_tdata[50:19];

    always_comb begin
        item.clear    = s_axis_tuser[0];
        item.onscreen = (CW'(pos_x) < CW'(SCREEN_COLS)) && (CW'(pos_y) < CW'(SCREEN_ROWS));
        item.addr     = AW'(pos_y) * AW'(SCREEN_COLS) + AW'(pos_x);
        item.depth    = depth;
    end

    assign s_axis_tready = (cnt_reg != 2'd2) && !hold;
    assign push          = s_axis_tvalid && s_axis_tready;
    assign q_valid       = (cnt_reg != 2'd0);
    assign q_item        = q_mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        cnt_next    = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

/* hdl/idbt_recip.sv */
// ----------------------------------------------------------------------------
// idbt_recip
// Radix-2 restoring divider for floor(2^32 / d), one quotient bit a cycle.
// Valid for d >= 2; saturation is handled by the caller.
// ----------------------------------------------------------------------------
module idbt_recip (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [idbt_pkg::DEPTH_W-1:0]  dvsr,
    output logic                          done,
    output logic [idbt_pkg::DEPTH_W-1:0]  quot
);

    localparam int W  = idbt_pkg::DEPTH_W;
    localparam int CW = $clog2(W);

    logic [W-1:0]  rem_reg,  rem_next;
    logic [W-1:0]  quot_reg, quot_next;
    logic [W-1:0]  dvsr_reg, dvsr_next;
    logic [CW-1:0] cnt_reg,  cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;
    logic          fits;

    assign trial = {rem_reg, 1'b0};
    assign fits  = trial >= {1'b0, dvsr_reg};

    always_comb begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        dvsr_next = dvsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            // leading dividend bit already brought down: remainder 1, quotient bit 0
            rem_next  = W'(1);
            quot_next = '0;
            dvsr_next = dvsr;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = fits ? W'(trial - {1'b0, dvsr_reg}) : trial[W-1:0];
            quot_next = {quot_reg[W-2:0], fits};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CW'(W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        dvsr_reg <= dvsr_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

/* hdl/idbt_back.sv */
// ----------------------------------------------------------------------------
// idbt_back
// Carries out queued requests: reciprocal, depth compare and update, clear
// sweep over the store, and the result register.
// ----------------------------------------------------------------------------
module idbt_back #(
    parameter int SCREEN_COLS = 640,
    parameter int SCREEN_ROWS = 480
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    input  idbt_pkg::item_t                q_item,
    output logic                           q_pop,
    output logic                           init_busy,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [idbt_pkg::M_DATA_W-1:0]  m_axis_tdata,
    output logic [0:0]                     m_axis_tuser
);

    localparam int W       = idbt_pkg::DEPTH_W;
    localparam int ENTRIES = SCREEN_COLS * SCREEN_ROWS;
    localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam logic [1:0] ST_SWEEP = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;
    localparam logic [1:0] ST_RES   = 2'd3;

    logic [1:0]        st_reg, st_next;
    logic              init_reg, init_next;
    logic [ADDR_W-1:0] sweep_reg, sweep_next;
    logic              sat_reg, sat_next;
    logic              onscr_reg, onscr_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              res_clr_reg, res_clr_next;
    logic              res_pass_reg, res_pass_next;
    logic [W-1:0]      res_inv_reg, res_inv_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_pass_reg, m_pass_next;
    logic [W-1:0]      m_inv_reg, m_inv_next;

    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr;
    logic [W-1:0]      ram_wdata, ram_rdata;
    logic              div_start, div_done;
    logic [W-1:0]      div_quot;
    logic [W-1:0]      inv;
    logic              slot_free;

    idbt_ram #(
        .DATA_W (W),
        .DEPTH  (ENTRIES)
    ) u_store (
        .aclk   (aclk),
        .we     (ram_we),
        .waddr  (ram_waddr),
        .wdata  (ram_wdata),
        .re     (ram_re),
        .raddr  (q_item.addr[ADDR_W-1:0]),
        .rdata  (ram_rdata)
    );

    idbt_recip u_recip (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dvsr    (q_item.depth),
        .done    (div_done),
        .quot    (div_quot)
    );

    assign inv       = sat_reg ? '1 : div_quot;
    assign slot_free = !m_valid_reg || m_axis_tready;

    always_comb begin
        st_next       = st_reg;
        init_next     = init_reg;
        sweep_next    = sweep_reg;
        sat_next      = sat_reg;
        onscr_next    = onscr_reg;
        addr_next     = addr_reg;
        res_clr_next  = res_clr_reg;
        res_pass_next = res_pass_reg;
        res_inv_next  = res_inv_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        m_pass_next   = m_pass_reg;
        m_inv_next    = m_inv_reg;
        q_pop         = 1'b0;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_waddr     = sweep_reg;
        ram_wdata     = '0;
        div_start     = 1'b0;

        unique case (st_reg)
            ST_SWEEP: begin
                ram_we = 1'b1;
                if (sweep_reg == ADDR_W'(ENTRIES - 1)) begin
                    st_next   = ST_IDLE;
                    init_next = 1'b0;
                end else begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    if (q_item.clear) begin
                        res_clr_next  = 1'b1;
                        res_pass_next = 1'b0;
                        res_inv_next  = '0;
                        sweep_next    = '0;
                        st_next       = ST_RES;
                    end else begin
                        ram_re       = q_item.onscreen;
                        div_start    = 1'b1;
                        sat_next     = (q_item.depth[W-1:1] == '0);
                        onscr_next   = q_item.onscreen;
                        addr_next    = q_item.addr[ADDR_W-1:0];
                        res_clr_next = 1'b0;
                        st_next      = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    res_inv_next  = inv;
                    res_pass_next = onscr_reg && !(ram_rdata > inv);
                    st_next       = ST_RES;
                end
            end
            ST_RES: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_pass_next  = res_pass_reg;
                    m_inv_next   = res_inv_reg;
                    ram_we       = res_pass_reg;
                    ram_waddr    = addr_reg;
                    ram_wdata    = res_inv_reg;
                    st_next      = res_clr_reg ? ST_SWEEP : ST_IDLE;
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= ST_SWEEP;
            init_reg     <= 1'b1;
            sweep_reg    <= '0;
            res_clr_reg  <= 1'b0;
            res_pass_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            m_pass_reg   <= 1'b0;
        end else begin
            st_reg       <= st_next;
            init_reg     <= init_next;
            sweep_reg    <= sweep_next;
            res_clr_reg  <= res_clr_next;
            res_pass_reg <= res_pass_next;
            m_valid_reg  <= m_valid_next;
            m_pass_reg   <= m_pass_next;
        end
        sat_reg     <= sat_next;
        onscr_reg   <= onscr_next;
        addr_reg    <= addr_next;
        res_inv_reg <= res_inv_next;
        m_inv_reg   <= m_inv_next;
    end

    assign init_busy     = init_reg;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_inv_reg;
    assign m_axis_tuser  = m_pass_reg;

endmodule

/* hdl/inverse_depth_buffer_test_core.sv */
// A depth test runs through the 32-step reciprocal divider (one quotient bit
// a cycle). One test is in flight at a time; two requests can queue in front.
// A clear returns its result, then sweeps all SCREEN_COLS*SCREEN_ROWS entries.
// Reset: synchronous, active low; afterwards the SCREEN_COLS*SCREEN_ROWS entries
// of the store are zeroed with s_axis_tready held low.
// ----------------------------------------------------------------------------
// inverse_depth_buffer_test_core
// Inverse-depth buffer test: per-pixel 1/z store with compare and update.
// ----------------------------------------------------------------------------
module inverse_depth_buffer_test_core #(
    parameter int SCREEN_COLS = 640,
    parameter int SCREEN_ROWS = 480
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [9:0] pos_x, [18:10] pos_y, [50:19] depth, [55:51] zero
    input  logic [idbt_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // [0] action
    input  logic [0:0]                     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [31:0] inverse_depth
    output logic [idbt_pkg::M_DATA_W-1:0]  m_axis_tdata,
    // [0] passed
    output logic [0:0]                     m_axis_tuser
);

    logic            q_valid;
    logic            q_pop;
    logic            init_busy;
    idbt_pkg::item_t q_item;

    idbt_front #(
        .SCREEN_COLS (SCREEN_COLS),
        .SCREEN_ROWS (SCREEN_ROWS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .hold          (init_busy),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    idbt_back #(
        .SCREEN_COLS (SCREEN_COLS),
        .SCREEN_ROWS (SCREEN_ROWS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .init_busy     (init_busy),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

/* hdl/idbt_checker.sv */
// ----------------------------------------------------------------------------
// idbt_checker
// Port-level checks for the inverse-depth buffer test core.
// ----------------------------------------------------------------------------
module idbt_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [idbt_pkg::S_DATA_W-1:0]  s_axis_tdata,
    input logic [0:0]                     s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [idbt_pkg::M_DATA_W-1:0]  m_axis_tdata,
    input logic [0:0]                     m_axis_tuser
);

    // a waiting request is held by the sender
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata)
            && $stable(s_axis_tuser))
        else $error("request dropped or changed while waiting");

    // a stalled result is held
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result dropped or changed while stalled");

    // a pass always carries a non-zero reciprocal
    a_pass_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata != '0)
        else $error("passed result with zero inverse depth");

    // no result straight out of reset
    a_rst_out: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // store clearing pass follows reset, so no request is taken
    a_rst_sweep: assert property (@(posedge aclk)
        !aresetn |=> !s_axis_tready)
        else $error("request accepted during clearing pass");

endmodule

bind inverse_depth_buffer_test_core idbt_checker u_idbt_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for inverse_depth_buffer_test_core at 640 x 480. Drives
// depth tests and clears through the input stream, keeps its own per-pixel
// 1/z store, and checks every returned request against the predicted verdict
// and reciprocal. Both stream sides idle at random, and one long output stall
// backs the core up.
// ----------------------------------------------------------------------------
module testbench;

    localparam int DEPTH_W  = idbt_pkg::DEPTH_W;
    localparam int POS_X_W  = idbt_pkg::POS_X_W;
    localparam int POS_Y_W  = idbt_pkg::POS_Y_W;
    localparam int S_DATA_W = idbt_pkg::S_DATA_W;
    localparam int M_DATA_W = idbt_pkg::M_DATA_W;

    localparam int SCREEN_COLS   = 640;
    localparam int SCREEN_ROWS   = 480;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 80;
    localparam int PRINT_CAP     = 100;

    localparam logic [POS_X_W-1:0] LAST_COL = POS_X_W'(SCREEN_COLS - 1);
    localparam logic [POS_Y_W-1:0] LAST_ROW = POS_Y_W'(SCREEN_ROWS - 1);
    localparam logic [POS_X_W-1:0] OFF_COL  = POS_X_W'(SCREEN_COLS);
    localparam logic [POS_Y_W-1:0] OFF_ROW  = POS_Y_W'(SCREEN_ROWS);

    localparam logic ACT_TEST  = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    localparam logic [DEPTH_W-1:0] INV_SATURATED = {DEPTH_W{1'b1}};

    typedef struct {
        logic               passed;
        logic [DEPTH_W-1:0] inv_depth;
    } verdict_t;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata  = '0;
    logic [0:0]            s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic [0:0]            m_axis_tuser;

    bit steady   = 1'b0;
    bit hold_req = 1'b0;

    logic [DEPTH_W-1:0] inv_store [int unsigned];
    verdict_t           pending_verdicts [$];

    int unsigned fail_count  = 0;
    int unsigned n_tests     = 0;
    int unsigned n_clears    = 0;
    int unsigned n_visible   = 0;
    int unsigned n_hidden    = 0;
    int unsigned n_offscreen = 0;
    int unsigned n_saturated = 0;
    int unsigned n_results   = 0;

    inverse_depth_buffer_test_core #(
        .SCREEN_COLS (SCREEN_COLS),
        .SCREEN_ROWS (SCREEN_ROWS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        #(12 * 4_000_000);
        $display("%0t: timeout, %0d requests still outstanding", $time,
                 pending_verdicts.size());
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [DEPTH_W-1:0] reciprocal_of(input logic [DEPTH_W-1:0] z);
        logic [63:0] quotient;
        if (z <= 1)
            return INV_SATURATED;
        quotient = 64'h1_0000_0000 / {32'h0, z};
        return quotient[DEPTH_W-1:0];
    endfunction

    function automatic void predict_request(input logic act, input logic [POS_X_W-1:0] x,
                                            input logic [POS_Y_W-1:0] y,
                                            input logic [DEPTH_W-1:0] z);
        verdict_t           v;
        int unsigned        addr;
        logic [DEPTH_W-1:0] held;
        if (act == ACT_CLEAR) begin
            inv_store.delete();
            v.passed    = 1'b0;
            v.inv_depth = '0;
            n_clears++;
        end else begin
            n_tests++;
            v.inv_depth = reciprocal_of(z);
            v.passed    = 1'b0;
            if (v.inv_depth == INV_SATURATED)
                n_saturated++;
            if (x < SCREEN_COLS && y < SCREEN_ROWS) begin
                addr = y * SCREEN_COLS + x;
                held = inv_store.exists(addr) ? inv_store[addr] : '0;
                if (held <= v.inv_depth) begin
                    inv_store[addr] = v.inv_depth;
                    v.passed        = 1'b1;
                    n_visible++;
                end else begin
                    n_hidden++;
                end
            end else begin
                n_offscreen++;
            end
        end
        pending_verdicts.push_back(v);
    endfunction

    // request held until accepted; predicted at the accepting edge
    task automatic send_request(input logic act, input logic [POS_X_W-1:0] x,
                                input logic [POS_Y_W-1:0] y, input logic [DEPTH_W-1:0] z);
        if (!steady && $urandom_range(0, 99) < 16) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < 16);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_DATA_W-DEPTH_W-POS_Y_W-POS_X_W){1'b0}}, z, y, x};
        s_axis_tuser  <= act;
        do @(posedge aclk); while (!(aresetn && s_axis_tready));
        predict_request(act, x, y, z);
    endtask

    task automatic flag_mismatch(input string what, input logic [DEPTH_W-1:0] want,
                                 input logic [DEPTH_W-1:0] got);
        if (fail_count < PRINT_CAP)
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
        fail_count++;
    endtask

    // result sink: random stalls, plus a counted hold-off on request
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_left != 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= steady || ($urandom_range(0, 99) >= 16);
            end
        end
    end

    initial begin
        verdict_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_axis_tvalid && m_axis_tready) begin
                n_results++;
                if (pending_verdicts.size() == 0) begin
                    if (fail_count < PRINT_CAP)
                        $display("%0t: unexpected result passed=%0b inverse_depth=%h, expected none",
                                 $time, m_axis_tuser[0], m_axis_tdata);
                    fail_count++;
                end else begin
                    want = pending_verdicts.pop_front();
                    if (m_axis_tuser[0] !== want.passed)
                        flag_mismatch("passed", DEPTH_W'(want.passed),
                                      DEPTH_W'(m_axis_tuser[0]));
                    if (m_axis_tdata !== want.inv_depth)
                        flag_mismatch("inverse_depth", want.inv_depth, m_axis_tdata);
                end
            end
        end
    end

    task automatic test_directed_cases();
        // zero and unit depth saturate; store is all zero after reset
        send_request(ACT_TEST, 0, 0, 32'h0000_0000);
        send_request(ACT_TEST, LAST_COL, LAST_ROW, 32'h0000_0001);
        send_request(ACT_TEST, 1, 0, 32'h0000_0002);
        send_request(ACT_TEST, 2, 0, 32'hFFFF_FFFF);
        send_request(ACT_TEST, 3, 1, 32'h0001_0000);
        // hidden fragment still reports its reciprocal
        send_request(ACT_TEST, 0, 0, 32'h0001_0000);
        send_request(ACT_TEST, LAST_COL, LAST_ROW, 32'hFFFF_FFFF);
        // equal values pass and rewrite; then a nearer one passes, a farther one is hidden
        send_request(ACT_TEST, 1, 0, 32'h0000_0002);
        send_request(ACT_TEST, 2, 0, 32'hFFFF_FFFF);
        send_request(ACT_TEST, 2, 0, 32'h8000_0000);
        send_request(ACT_TEST, 3, 1, 32'h0001_0001);
        // off screen: no access, reciprocal still returned; then one at the last column
        send_request(ACT_TEST, OFF_COL, 0, 32'h0000_0000);
        send_request(ACT_TEST, 10'h3FF, 9'h1FF, 32'h0000_0003);
        send_request(ACT_TEST, 0, OFF_ROW, 32'h0001_0000);
        send_request(ACT_TEST, LAST_COL, 0, 32'h0000_0004);
        // clear ignores its other fields
        send_request(ACT_CLEAR, 10'h2AA, 9'h155, 32'hDEAD_BEEF);
        send_request(ACT_TEST, 0, 0, 32'hFFFF_FFFF);
        send_request(ACT_TEST, LAST_COL, LAST_ROW, 32'h7FFF_FFFF);
        send_request(ACT_TEST, 0, 0, 32'hFFFF_FFFF);
    endtask

    task automatic test_output_backpressure();
        steady   = 1'b1;
        hold_req = 1'b1;
        for (int i = 0; i < 12; i++)
            send_request(ACT_TEST, POS_X_W'($urandom_range(0, 3)), 0, $urandom);
        steady = 1'b0;
    endtask

    task automatic test_random_fragments(input int unsigned count);
        logic [POS_X_W-1:0] x;
        logic [POS_Y_W-1:0] y;
        logic [DEPTH_W-1:0] z;
        int unsigned        pick;
        for (int unsigned i = 0; i < count; i++) begin
            steady = (i >= 300 && i < 450);
            if (i == count / 2)
                send_request(ACT_CLEAR, POS_X_W'($urandom), POS_Y_W'($urandom), $urandom);
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                // small hot window so pixels are hit repeatedly
                x = POS_X_W'($urandom_range(0, 7));
                y = POS_Y_W'($urandom_range(0, 3));
            end else if (pick < 60) begin
                x = POS_X_W'($urandom_range(SCREEN_COLS - 8, SCREEN_COLS - 1));
                y = POS_Y_W'($urandom_range(SCREEN_ROWS - 4, SCREEN_ROWS - 1));
            end else if (pick < 85) begin
                x = POS_X_W'($urandom_range(0, SCREEN_COLS - 1));
                y = POS_Y_W'($urandom_range(0, SCREEN_ROWS - 1));
            end else begin
                x = POS_X_W'($urandom);
                y = POS_Y_W'($urandom);
            end
            pick = $urandom_range(0, 99);
            if (pick < 8)
                z = $urandom_range(0, 3);
            else if (pick < 20)
                z = $urandom;
            else
                z = $urandom >> $urandom_range(0, 31);
            send_request(ACT_TEST, x, y, z);
        end
        steady = 1'b0;
    endtask

    initial begin
        aresetn <= 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();
        test_output_backpressure();
        test_random_fragments(1160);
        s_axis_tvalid <= 1'b0;

        while (pending_verdicts.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Covered %0d depth tests and %0d clears: %0d visible, %0d hidden, %0d off screen,",
                 n_tests, n_clears, n_visible, n_hidden, n_offscreen);
        $display("%0d saturated reciprocals, %0d results checked, %0d mismatches.",
                 n_saturated, n_results, fail_count);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
